// File: design/factorization_machine_sgd_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the factorization machine SGD unit
// Short forms for clocked implication checks with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef FACTORIZATION_MACHINE_SGD_UNIT_MACROS_SVH
`define FACTORIZATION_MACHINE_SGD_UNIT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds at that edge.
`define FMSGD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmsgd same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define FMSGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmsgd next-cycle check failed");

`endif

// File: design/fmsgd_pkg.sv
// ----------------------------------------------------------------------------
// fmsgd_pkg
// Shared field widths, codes, command format and saturation helper.
// ----------------------------------------------------------------------------
package fmsgd_pkg;

    localparam int ACTION_W  = 2;
    localparam int USER_W    = 10;
    localparam int ITEM_W    = 11;
    localparam int RATING_W  = 31;
    localparam int FSLOT_W   = 12;
    localparam int KSLOT_W   = 4;
    localparam int Q_W       = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_Q_W   = 17;
    localparam int CFG_NF_W  = 5;

    localparam logic [ACTION_W-1:0] ACTION_TRAIN   = 2'd0;
    localparam logic [ACTION_W-1:0] ACTION_PREDICT = 2'd1;
    localparam logic [ACTION_W-1:0] ACTION_LOAD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGZ    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTORS = 2'd2;

    localparam logic [1:0] KIND_NULL = 2'd0;
    localparam logic [1:0] KIND_LOAD = 2'd1;
    localparam logic [1:0] KIND_EVAL = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic                train;
        logic [USER_W-1:0]   user;
        logic [ITEM_W-1:0]   item;
        logic [RATING_W-1:0] rating;
        logic [FSLOT_W-1:0]  fslot;
        logic [KSLOT_W-1:0]  kslot;
        logic [Q_W-1:0]      value;
    } cmd_t;

    typedef struct packed {
        logic [CFG_Q_W-1:0]  step;
        logic [CFG_Q_W-1:0]  regz;
        logic [CFG_NF_W-1:0] nfac;
    } cfg_t;

    typedef struct packed {
        logic               flag;
        logic signed [31:0] value;
    } clip_t;

    // Clamp a wide signed value to the Q16.16 range and flag any clipping.
    function automatic clip_t clip_q(input logic signed [63:0] x);
        clip_t r;
        if (x > 64'sd2147483647) begin
            r.flag  = 1'b1;
            r.value = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r.flag  = 1'b1;
            r.value = 32'sh80000000;
        end else begin
            r.flag  = 1'b0;
            r.value = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: design/fmsgd_front.sv
// ----------------------------------------------------------------------------
// fmsgd_front
// Accepts input beats and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module fmsgd_front #(
    parameter int USER_COUNT  = 1024,
    parameter int ITEM_COUNT  = 2048,
    parameter int MAX_FACTORS = 16
) (
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fmsgd_pkg::ACTION_W-1:0]  action,
    input  logic [fmsgd_pkg::USER_W-1:0]    user_index,
    input  logic [fmsgd_pkg::ITEM_W-1:0]    item_index,
    input  logic [fmsgd_pkg::RATING_W-1:0]  rating,
    input  logic [fmsgd_pkg::FSLOT_W-1:0]   feature_slot,
    input  logic [fmsgd_pkg::KSLOT_W-1:0]   factor_slot,
    input  logic [fmsgd_pkg::Q_W-1:0]       load_value,
    input  logic                            clearing,
    input  logic                            q_full,
    output logic                            push,
    output fmsgd_pkg::cmd_t                 cmd
);
    import fmsgd_pkg::*;

    localparam int NUM_FEATURES = USER_COUNT + ITEM_COUNT;

    logic users_ok;
    logic load_ok;

    assign users_ok = (32'(user_index) < USER_COUNT) && (32'(item_index) < ITEM_COUNT);
    assign load_ok  = (32'(feature_slot) < NUM_FEATURES) && (32'(factor_slot) < MAX_FACTORS);

    // Nothing is taken while the weight store is being swept after reset.
    assign in_stall = clearing || q_full;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        cmd.kind   = KIND_NULL;
        cmd.train  = 1'b0;
        cmd.user   = user_index;
        cmd.item   = item_index;
        cmd.rating = rating;
        cmd.fslot  = feature_slot;
        cmd.kslot  = factor_slot;
        cmd.value  = load_value;
        unique case (action)
            ACTION_LOAD:
            begin
                cmd.kind = load_ok ? KIND_LOAD : KIND_NULL;
            end
            ACTION_TRAIN, ACTION_PREDICT:
            begin
                cmd.kind  = users_ok ? KIND_EVAL : KIND_NULL;
                cmd.train = users_ok && (action == ACTION_TRAIN) && (rating != '0);
            end
            default:
            begin
                cmd.kind = KIND_NULL;
            end
        endcase
    end

endmodule

// File: design/fmsgd_queue.sv
// ----------------------------------------------------------------------------
// fmsgd_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module fmsgd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fmsgd_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output fmsgd_pkg::cmd_t head
);
    import fmsgd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/fmsgd_back.sv
// ----------------------------------------------------------------------------
// fmsgd_back
// Sequencer that loads, predicts and trains over the weight and latent memories.
// ----------------------------------------------------------------------------
`include "factorization_machine_sgd_unit_macros.svh"

module fmsgd_back #(
    parameter int USER_COUNT  = 1024,
    parameter int ITEM_COUNT  = 2048,
    parameter int MAX_FACTORS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fmsgd_pkg::cfg_t             cfg,
    input  logic                        q_valid,
    input  fmsgd_pkg::cmd_t             q_cmd,
    output logic                        q_pop,
    output logic                        clearing,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [fmsgd_pkg::Q_W-1:0]   prediction,
    output logic [fmsgd_pkg::Q_W-1:0]   residual,
    output logic                        updated,
    output logic                        saturated
);
    import fmsgd_pkg::*;

    localparam int NUM_FEATURES = USER_COUNT + ITEM_COUNT;
    localparam int FW           = $clog2(NUM_FEATURES);
    localparam int LDEPTH       = MAX_FACTORS * NUM_FEATURES;
    localparam int LW           = $clog2(LDEPTH);
    localparam int KW           = $clog2(MAX_FACTORS + 1);

    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_WU    = 5'd2;
    localparam logic [4:0] ST_WI    = 5'd3;
    localparam logic [4:0] ST_DINIT = 5'd4;
    localparam logic [4:0] ST_DRU   = 5'd5;
    localparam logic [4:0] ST_DRI   = 5'd6;
    localparam logic [4:0] ST_DMUL  = 5'd7;
    localparam logic [4:0] ST_DACC  = 5'd8;
    localparam logic [4:0] ST_PRED  = 5'd9;
    localparam logic [4:0] ST_LRU   = 5'd10;
    localparam logic [4:0] ST_LRI   = 5'd11;
    localparam logic [4:0] ST_LEV   = 5'd12;
    localparam logic [4:0] ST_LEU   = 5'd13;
    localparam logic [4:0] ST_LGI   = 5'd14;
    localparam logic [4:0] ST_S1    = 5'd15;
    localparam logic [4:0] ST_S2    = 5'd16;
    localparam logic [4:0] ST_S3    = 5'd17;
    localparam logic [4:0] ST_S4    = 5'd18;
    localparam logic [4:0] ST_S5    = 5'd19;
    localparam logic [4:0] ST_S6    = 5'd20;
    localparam logic [4:0] ST_DONE  = 5'd21;

    localparam logic [2:0] TGT_BIAS = 3'd0;
    localparam logic [2:0] TGT_WU   = 3'd1;
    localparam logic [2:0] TGT_WI   = 3'd2;
    localparam logic [2:0] TGT_VU   = 3'd3;
    localparam logic [2:0] TGT_VI   = 3'd4;

    logic signed [31:0] wmem [NUM_FEATURES];
    logic signed [31:0] lmem [LDEPTH];

    logic [4:0]          state_reg,   state_next;
    cmd_t                cmd_reg,     cmd_next;
    logic [FW-1:0]       clr_reg,     clr_next;
    logic [KW-1:0]       k_reg,       k_next;
    logic [LW-1:0]       base_reg,    base_next;
    logic [2:0]          tgt_reg,     tgt_next;
    logic signed [31:0]  bias_reg,    bias_next;
    logic signed [31:0]  wu_reg,      wu_next;
    logic signed [31:0]  wi_reg,      wi_next;
    logic signed [31:0]  vu_reg,      vu_next;
    logic signed [31:0]  vi_reg,      vi_next;
    logic signed [31:0]  pred_reg,    pred_next;
    logic signed [31:0]  err_reg,     err_next;
    logic                upd_reg,     upd_next;
    logic                sat_reg,     sat_next;
    logic signed [63:0]  acc_reg,     acc_next;
    logic signed [65:0]  prod_reg,    prod_next;
    logic [41:0]         plo_reg,     plo_next;
    logic signed [49:0]  inner_reg,   inner_next;
    logic signed [51:0]  scaled_reg,  scaled_next;
    logic signed [48:0]  gu_reg,      gu_next;
    logic signed [48:0]  gi_reg,      gi_next;
    logic                out_valid_reg, out_valid_next;
    logic [Q_W-1:0]      out_pred_reg,  out_pred_next;
    logic [Q_W-1:0]      out_res_reg,   out_res_next;
    logic                out_upd_reg,   out_upd_next;
    logic                out_sat_reg,   out_sat_next;
    logic signed [31:0]  wrd_reg;
    logic signed [31:0]  lrd_reg;

    logic [31:0]         iu_full;
    logic [31:0]         ii_full;
    logic [31:0]         la_full;
    logic [31:0]         nf_full;
    logic [FW-1:0]       iu;
    logic [FW-1:0]       ii;
    logic [KW-1:0]       nf;
    logic [LW-1:0]       lat_u;
    logic [LW-1:0]       lat_i;
    logic                out_free;
    logic                last_k;
    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  mul_p;
    logic signed [47:0]  floor48;
    logic signed [31:0]  old_val;
    logic signed [49:0]  grad;
    logic signed [67:0]  sum68;
    clip_t               pred_c;
    clip_t               err_c;
    clip_t               new_c;
    logic                w_we;
    logic [FW-1:0]       w_raddr;
    logic [FW-1:0]       w_waddr;
    logic signed [31:0]  w_wdata;
    logic                l_we;
    logic [LW-1:0]       l_raddr;
    logic [LW-1:0]       l_waddr;
    logic signed [31:0]  l_wdata;

    assign iu_full = 32'(cmd_reg.user);
    assign ii_full = 32'(cmd_reg.item) + USER_COUNT;
    assign la_full = 32'(q_cmd.kslot) * NUM_FEATURES + 32'(q_cmd.fslot);
    assign nf_full = (32'(cfg.nfac) > MAX_FACTORS) ? MAX_FACTORS : 32'(cfg.nfac);
    assign iu      = iu_full[FW-1:0];
    assign ii      = ii_full[FW-1:0];
    assign nf      = nf_full[KW-1:0];
    assign lat_u   = base_reg + LW'(iu);
    assign lat_i   = base_reg + LW'(ii);
    assign last_k  = ((k_reg + KW'(1)) == nf);
    assign out_free = !out_valid_reg || !out_stall;

    assign clearing   = (state_reg == ST_CLEAR);
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign out_valid  = out_valid_reg;
    assign prediction = out_pred_reg;
    assign residual   = out_res_reg;
    assign updated    = out_upd_reg;
    assign saturated  = out_sat_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DMUL:
            begin
                mul_a = 33'(vu_reg);
                mul_b = 33'(lrd_reg);
            end
            ST_LEV:
            begin
                mul_a = 33'(err_reg);
                mul_b = 33'(lrd_reg);
            end
            ST_LEU:
            begin
                mul_a = 33'(err_reg);
                mul_b = 33'(vu_reg);
            end
            ST_S1:
            begin
                mul_a = $signed({16'b0, cfg.regz});
                mul_b = 33'(old_val);
            end
            ST_S3:
            begin
                mul_a = $signed({16'b0, cfg.step});
                mul_b = $signed({8'b0, inner_reg[24:0]});
            end
            ST_S4:
            begin
                mul_a = $signed({16'b0, cfg.step});
                mul_b = $signed({{8{inner_reg[49]}}, inner_reg[49:25]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign floor48 = 48'(prod_reg >>> 16);
    assign sum68   = (68'(prod_reg) <<< 25) + $signed({26'b0, plo_reg});

    always_comb
    begin
        unique case (tgt_reg)
            TGT_BIAS: old_val = bias_reg;
            TGT_WU:   old_val = wu_reg;
            TGT_WI:   old_val = wi_reg;
            TGT_VU:   old_val = vu_reg;
            TGT_VI:   old_val = vi_reg;
            default:  old_val = bias_reg;
        endcase
        unique case (tgt_reg)
            TGT_VU:  grad = 50'(gu_reg);
            TGT_VI:  grad = 50'(gi_reg);
            default: grad = $signed({{17{err_reg[31]}}, err_reg, 1'b0});
        endcase
    end

    assign pred_c = clip_q(acc_reg);
    assign err_c  = clip_q($signed({33'b0, cmd_reg.rating}) - 64'(pred_c.value));
    assign new_c  = clip_q(64'(old_val) + 64'(scaled_reg));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        base_next      = base_reg;
        tgt_next       = tgt_reg;
        bias_next      = bias_reg;
        wu_next        = wu_reg;
        wi_next        = wi_reg;
        vu_next        = vu_reg;
        vi_next        = vi_reg;
        pred_next      = pred_reg;
        err_next       = err_reg;
        upd_next       = upd_reg;
        sat_next       = sat_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        plo_next       = plo_reg;
        inner_next     = inner_reg;
        scaled_next    = scaled_reg;
        gu_next        = gu_reg;
        gi_next        = gi_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_pred_next  = out_pred_reg;
        out_res_next   = out_res_reg;
        out_upd_next   = out_upd_reg;
        out_sat_next   = out_sat_reg;
        w_we           = 1'b0;
        w_raddr        = iu;
        w_waddr        = iu;
        w_wdata        = new_c.value;
        l_we           = 1'b0;
        l_raddr        = lat_u;
        l_waddr        = lat_u;
        l_wdata        = new_c.value;

        unique case (state_reg)
            ST_CLEAR:
            begin
                w_we    = 1'b1;
                w_waddr = clr_reg;
                w_wdata = '0;
                clr_next = clr_reg + FW'(1);
                if (clr_reg == FW'(NUM_FEATURES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next  = q_cmd;
                    pred_next = '0;
                    err_next  = '0;
                    upd_next  = 1'b0;
                    sat_next  = 1'b0;
                    if (q_cmd.kind == KIND_EVAL)
                    begin
                        state_next = ST_WU;
                    end
                    else
                    begin
                        if (q_cmd.kind == KIND_LOAD)
                        begin
                            l_we    = 1'b1;
                            l_waddr = la_full[LW-1:0];
                            l_wdata = q_cmd.value;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WU:
            begin
                w_raddr    = iu;
                state_next = ST_WI;
            end
            ST_WI:
            begin
                wu_next    = wrd_reg;
                w_raddr    = ii;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                wi_next   = wrd_reg;
                acc_next  = 64'(bias_reg) + 64'(wu_reg) + 64'(wrd_reg);
                k_next    = '0;
                base_next = '0;
                state_next = (nf == '0) ? ST_PRED : ST_DRU;
            end
            ST_DRU:
            begin
                l_raddr    = lat_u;
                state_next = ST_DRI;
            end
            ST_DRI:
            begin
                vu_next    = lrd_reg;
                l_raddr    = lat_i;
                state_next = ST_DMUL;
            end
            ST_DMUL:
            begin
                prod_next  = mul_p;
                state_next = ST_DACC;
            end
            ST_DACC:
            begin
                acc_next  = acc_reg + 64'(floor48);
                k_next    = k_reg + KW'(1);
                base_next = base_reg + LW'(NUM_FEATURES);
                state_next = last_k ? ST_PRED : ST_DRU;
            end
            ST_PRED:
            begin
                pred_next = pred_c.value;
                sat_next  = sat_reg || pred_c.flag || (cmd_reg.train && err_c.flag);
                upd_next  = cmd_reg.train;
                err_next  = cmd_reg.train ? err_c.value : '0;
                tgt_next  = TGT_BIAS;
                state_next = cmd_reg.train ? ST_S1 : ST_DONE;
            end
            ST_LRU:
            begin
                l_raddr    = lat_u;
                state_next = ST_LRI;
            end
            ST_LRI:
            begin
                vu_next    = lrd_reg;
                l_raddr    = lat_i;
                state_next = ST_LEV;
            end
            ST_LEV:
            begin
                vi_next    = lrd_reg;
                prod_next  = mul_p;
                state_next = ST_LEU;
            end
            ST_LEU:
            begin
                gu_next    = $signed({floor48, 1'b0});
                prod_next  = mul_p;
                state_next = ST_LGI;
            end
            ST_LGI:
            begin
                gi_next    = $signed({floor48, 1'b0});
                tgt_next   = TGT_VU;
                state_next = ST_S1;
            end
            ST_S1:
            begin
                prod_next  = mul_p;
                state_next = ST_S2;
            end
            ST_S2:
            begin
                inner_next = grad - 50'(prod_reg >>> 16);
                state_next = ST_S3;
            end
            ST_S3:
            begin
                prod_next  = mul_p;
                state_next = ST_S4;
            end
            ST_S4:
            begin
                plo_next   = prod_reg[41:0];
                prod_next  = mul_p;
                state_next = ST_S5;
            end
            ST_S5:
            begin
                scaled_next = 52'(sum68 >>> 16);
                state_next  = ST_S6;
            end
            ST_S6:
            begin
                sat_next = sat_reg || new_c.flag;
                unique case (tgt_reg)
                    TGT_BIAS:
                    begin
                        bias_next  = new_c.value;
                        tgt_next   = TGT_WU;
                        state_next = ST_S1;
                    end
                    TGT_WU:
                    begin
                        w_we       = 1'b1;
                        w_waddr    = iu;
                        tgt_next   = TGT_WI;
                        state_next = ST_S1;
                    end
                    TGT_WI:
                    begin
                        w_we      = 1'b1;
                        w_waddr   = ii;
                        k_next    = '0;
                        base_next = '0;
                        state_next = (nf == '0) ? ST_DONE : ST_LRU;
                    end
                    TGT_VU:
                    begin
                        l_we       = 1'b1;
                        l_waddr    = lat_u;
                        tgt_next   = TGT_VI;
                        state_next = ST_S1;
                    end
                    default:
                    begin
                        l_we      = 1'b1;
                        l_waddr   = lat_i;
                        k_next    = k_reg + KW'(1);
                        base_next = base_reg + LW'(NUM_FEATURES);
                        state_next = last_k ? ST_DONE : ST_LRU;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pred_next  = pred_reg;
                    out_res_next   = err_reg;
                    out_upd_next   = upd_reg;
                    out_sat_next   = sat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[w_waddr] <= w_wdata;
        end
        wrd_reg <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            lmem[l_waddr] <= l_wdata;
        end
        lrd_reg <= lmem[l_raddr];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        wu_reg       <= wu_next;
        wi_reg       <= wi_next;
        vu_reg       <= vu_next;
        vi_reg       <= vi_next;
        pred_reg     <= pred_next;
        err_reg      <= err_next;
        upd_reg      <= upd_next;
        sat_reg      <= sat_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        plo_reg      <= plo_next;
        inner_reg    <= inner_next;
        scaled_reg   <= scaled_next;
        gu_reg       <= gu_next;
        gi_reg       <= gi_next;
        out_pred_reg <= out_pred_next;
        out_res_reg  <= out_res_next;
        out_upd_reg  <= out_upd_next;
        out_sat_reg  <= out_sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            base_reg      <= '0;
            tgt_reg       <= TGT_BIAS;
            bias_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            base_reg      <= base_next;
            tgt_reg       <= tgt_next;
            bias_reg      <= bias_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FMSGD_ASSERT_NEXT(a_done_delivers, clk, rst_n, (state_reg == ST_DONE) && out_free, out_valid_reg)
    `FMSGD_ASSERT_IMPL(a_no_pop_in_clear, clk, rst_n, state_reg == ST_CLEAR, !q_pop)
    `FMSGD_ASSERT_IMPL(a_lat_write_state, clk, rst_n, l_we, (state_reg == ST_IDLE) || (state_reg == ST_S6))
    `FMSGD_ASSERT_IMPL(a_factor_bound, clk, rst_n, (state_reg == ST_DRU) || (state_reg == ST_LRU), k_reg < nf)

endmodule

// File: design/factorization_machine_sgd_unit.sv
// ----------------------------------------------------------------------------
// factorization_machine_sgd_unit
// Two-hot factorization machine that predicts and trains in Q16.16.
// ----------------------------------------------------------------------------
// Usage: request beats arrive on in_valid/in_stall with the action and its
// fields; each request gives exactly one result beat on out_valid/out_stall.
// A train beat with a nonzero rating returns the prediction, the residual and
// updates bias, both linear weights and both latent columns; predict returns
// only the prediction; load writes one latent entry and answers zeros.
// Configuration is written through cfg_valid/cfg_ready (always ready); the
// user must write only while the unit is idle; the block does not enforce it.
// The back end works on one beat at a time and pops the next only after
// the last result has entered the output register. Its pace is set by the
// single shared 33x33 multiplier and the single read port of the latent
// memory, which each factor visits in turn.
// Reset: the linear weight memory is swept to zero, one entry per cycle, over
// all USER_COUNT + ITEM_COUNT entries, while in_stall is held high. Latent
// entries are not cleared and must be loaded before use.
// A stalled receiver holds the result in the output register; the front and
// a two-entry queue keep accepting until that queue is full.
// ----------------------------------------------------------------------------
module factorization_machine_sgd_unit #(
    parameter int USER_COUNT  = 1024,
    parameter int ITEM_COUNT  = 2048,
    parameter int MAX_FACTORS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fmsgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fmsgd_pkg::CFG_Q_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fmsgd_pkg::ACTION_W-1:0]  action,
    input  logic [fmsgd_pkg::USER_W-1:0]    user_index,
    input  logic [fmsgd_pkg::ITEM_W-1:0]    item_index,
    input  logic [fmsgd_pkg::RATING_W-1:0]  rating,
    input  logic [fmsgd_pkg::FSLOT_W-1:0]   feature_slot,
    input  logic [fmsgd_pkg::KSLOT_W-1:0]   factor_slot,
    input  logic [fmsgd_pkg::Q_W-1:0]       load_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fmsgd_pkg::Q_W-1:0]       prediction,
    output logic [fmsgd_pkg::Q_W-1:0]       residual,
    output logic                            updated,
    output logic                            saturated
);
    import fmsgd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic clearing;

    // The register file never holds off a write.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STEP:    cfg_next.step = cfg_data;
                CFG_REGZ:    cfg_next.regz = cfg_data;
                CFG_FACTORS: cfg_next.nfac = cfg_data[CFG_NF_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step <= 17'd655;
            cfg_reg.regz <= 17'd655;
            cfg_reg.nfac <= 5'd16;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: takes beats and sorts them into load, evaluate or null.
    fmsgd_front #(
        .USER_COUNT  (USER_COUNT),
        .ITEM_COUNT  (ITEM_COUNT),
        .MAX_FACTORS (MAX_FACTORS)
    ) u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .user_index   (user_index),
        .item_index   (item_index),
        .rating       (rating),
        .feature_slot (feature_slot),
        .factor_slot  (factor_slot),
        .load_value   (load_value),
        .clearing     (clearing),
        .q_full       (q_full),
        .push         (push),
        .cmd          (front_cmd)
    );

    // Short queue so the front and the back end stall independently.
    fmsgd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    // Back end: memories, shared multiplier and the output register.
    fmsgd_back #(
        .USER_COUNT  (USER_COUNT),
        .ITEM_COUNT  (ITEM_COUNT),
        .MAX_FACTORS (MAX_FACTORS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_cmd      (head_cmd),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .prediction (prediction),
        .residual   (residual),
        .updated    (updated),
        .saturated  (saturated)
    );

endmodule
